[sv/qks_pkg.sv]
// ============================================================================
// qks_pkg
// shared constants and types for the quicksort key sorter
// ============================================================================
package qks_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int RANGE_W   = 2 * IDX_W;
    localparam int STACK_W   = IDX_W;

    localparam logic [0:0] REG_DESCENDING  = 1'b0;
    localparam logic [0:0] REG_SIGNED_KEYS = 1'b1;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [IDX_W-1:0]     idx_t;

    // true when a must come strictly before b
    function automatic logic key_before(input key_t a, input key_t b,
                                        input logic desc, input logic sgn);
        key_t va;
        key_t vb;
        va = a;
        vb = b;
        if (sgn)
        begin
            va[KEY_WIDTH-1] = ~va[KEY_WIDTH-1];
            vb[KEY_WIDTH-1] = ~vb[KEY_WIDTH-1];
        end
        if (desc)
        begin
            va = ~va;
            vb = ~vb;
        end
        return va < vb;
    endfunction

endpackage

[sv/qks_ram.sv]
// ============================================================================
// qks_ram
// generic single-port ram with registered read
// ============================================================================
module qks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[sv/quicksort_key_sorter.sv]
// ============================================================================
// quicksort_key_sorter
// loads a set of keys, sorts them in place with hole-style quicksort on an
// explicit range stack, then streams them out in order
// ============================================================================
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+-------------------
//  input    | start, busy, key, last                   | start & !busy
//  result   | res_valid, sorted_key, final_res, dropped| strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| valid & ready
//
//  loading writes each key straight into the key ram; the sort then runs on
//  the single key ram port, and output reads each key in S_ORD and presents
//  it in S_OUT. busy stays high from the closing key until the last result.
//  reset clears the state, key count, overflow flag, stack pointer and the
//  config registers.
module quicksort_key_sorter
    import qks_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [31:0]           key,
    input  logic                  last,
    output logic                  res_valid,
    output logic [31:0]           sorted_key,
    output logic                  final_res,
    output logic                  dropped,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    typedef enum logic [14:0] {
        S_LOAD  = 15'b000000000000001,
        S_POP   = 15'b000000000000010,
        S_RDLO  = 15'b000000000000100,
        S_RDMID = 15'b000000000001000,
        S_RDHI  = 15'b000000000010000,
        S_MED   = 15'b000000000100000,
        S_RDPV  = 15'b000000001000000,
        S_JRD   = 15'b000000010000000,
        S_JCMP  = 15'b000000100000000,
        S_IRD   = 15'b000001000000000,
        S_ICMP  = 15'b000010000000000,
        S_PLACE = 15'b000100000000000,
        S_PUSH  = 15'b001000000000000,
        S_ORD   = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   desc_reg, sgn_reg;
    logic   sdesc_reg, ssgn_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic   ovf_reg, ovf_next;
    logic [STACK_W:0] sp_reg, sp_next;
    idx_t   lo_reg, lo_next, hi_reg, hi_next, i_reg, i_next, j_reg, j_next;
    idx_t   m_reg, m_next;
    key_t   a_reg, a_next, b_reg, b_next, pv_reg, pv_next;

    logic   k_we, s_we;
    idx_t   k_addr;
    key_t   k_wdata, k_rdata;
    logic [STACK_W-1:0] s_addr;
    logic [RANGE_W-1:0] s_wdata, s_rdata;

    qks_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_KEYS)) u_keys (
        .clk(clk), .we(k_we), .addr(k_addr), .wdata(k_wdata), .rdata(k_rdata)
    );

    qks_ram #(.WIDTH(RANGE_W), .DEPTH(MAX_KEYS)) u_stack (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
    );

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg <= 1'b0;
            sgn_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DESCENDING:  desc_reg <= cfg_data[0];
                REG_SIGNED_KEYS: sgn_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic cmp_jp, cmp_pi, c_ab, c_bc, c_ac;
    assign cmp_jp = key_before(k_rdata, pv_reg, sdesc_reg, ssgn_reg);
    assign cmp_pi = key_before(pv_reg, k_rdata, sdesc_reg, ssgn_reg);
    assign c_ab   = key_before(a_reg, b_reg, sdesc_reg, ssgn_reg);
    assign c_bc   = key_before(b_reg, k_rdata, sdesc_reg, ssgn_reg);
    assign c_ac   = key_before(a_reg, k_rdata, sdesc_reg, ssgn_reg);

    logic [IDX_W:0] mid_w;
    assign mid_w = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        sp_next    = sp_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        pv_next    = pv_reg;
        k_we       = 1'b0;
        k_addr     = i_reg;
        k_wdata    = key;
        s_we       = 1'b0;
        s_addr     = sp_reg[STACK_W-1:0];
        s_wdata    = {lo_reg, hi_reg};
        res_valid  = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                k_addr = count_reg[IDX_W-1:0];
                if (start)
                begin
                    if (count_reg < CNT_W'(MAX_KEYS))
                    begin
                        k_we       = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        i_next = '0;
                        if (count_next >= CNT_W'(2))
                        begin
                            s_we       = 1'b1;
                            s_addr     = '0;
                            s_wdata    = {idx_t'(0), idx_t'(count_next - 1'b1)};
                            sp_next    = (STACK_W+1)'(1);
                            state_next = S_POP;
                        end
                        else
                        begin
                            state_next = S_ORD;
                        end
                    end
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    i_next     = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    s_addr     = STACK_W'(sp_reg - 1'b1);
                    sp_next    = sp_reg - 1'b1;
                    state_next = S_RDLO;
                end
            end
            S_RDLO:
            begin
                lo_next = s_rdata[RANGE_W-1:IDX_W];
                hi_next = s_rdata[IDX_W-1:0];
                k_addr  = s_rdata[RANGE_W-1:IDX_W];
                if (s_rdata[RANGE_W-1:IDX_W] >= s_rdata[IDX_W-1:0])
                    state_next = S_POP;
                else
                    state_next = S_RDMID;
            end
            S_RDMID:
            begin
                a_next     = k_rdata;
                k_addr     = mid_w[IDX_W-1:0];
                m_next     = mid_w[IDX_W-1:0];
                state_next = S_RDHI;
            end
            S_RDHI:
            begin
                b_next     = k_rdata;
                k_addr     = hi_reg;
                state_next = S_MED;
            end
            S_MED:
            begin
                if (c_ab)
                begin
                    if (c_bc)
                    begin
                        pv_next = b_reg;
                    end
                    else if (c_ac)
                    begin
                        pv_next = k_rdata;
                        m_next  = hi_reg;
                    end
                    else
                    begin
                        pv_next = a_reg;
                        m_next  = lo_reg;
                    end
                end
                else
                begin
                    if (c_ac)
                    begin
                        pv_next = a_reg;
                        m_next  = lo_reg;
                    end
                    else if (c_bc)
                    begin
                        pv_next = k_rdata;
                        m_next  = hi_reg;
                    end
                    else
                    begin
                        pv_next = b_reg;
                    end
                end
                state_next = S_RDPV;
            end
            S_RDPV:
            begin
                // hole moves to lo: copy key_store[lo] into pivot slot
                k_we       = 1'b1;
                k_addr     = m_reg;
                k_wdata    = a_reg;
                i_next     = lo_reg;
                j_next     = hi_reg;
                state_next = S_JRD;
            end
            S_JRD:
            begin
                k_addr = j_reg;
                if (i_reg < j_reg) state_next = S_JCMP;
                else               state_next = S_PLACE;
            end
            S_JCMP:
            begin
                if (!cmp_jp && (i_reg < j_reg))
                begin
                    j_next     = j_reg - 1'b1;
                    k_addr     = j_reg - 1'b1;
                    if (i_reg < j_reg - 1'b1) state_next = S_JCMP;
                    else                      state_next = S_IRD;
                end
                else
                begin
                    k_we       = 1'b1;
                    k_addr     = i_reg;
                    k_wdata    = k_rdata;
                    state_next = S_IRD;
                end
            end
            S_IRD:
            begin
                k_addr     = i_reg;
                state_next = S_ICMP;
            end
            S_ICMP:
            begin
                if (i_reg < j_reg && !cmp_pi)
                begin
                    i_next     = i_reg + 1'b1;
                    k_addr     = i_reg + 1'b1;
                    state_next = S_ICMP;
                end
                else
                begin
                    k_we       = 1'b1;
                    k_addr     = j_reg;
                    k_wdata    = k_rdata;
                    state_next = S_JRD;
                end
            end
            S_PLACE:
            begin
                k_we       = 1'b1;
                k_addr     = i_reg;
                k_wdata    = pv_reg;
                state_next = S_PUSH;
                if ({1'b0, i_reg} + 1'b1 < {1'b0, hi_reg})
                begin
                    s_we    = 1'b1;
                    s_wdata = {idx_t'(i_reg + 1'b1), hi_reg};
                    sp_next = sp_reg + 1'b1;
                end
            end
            S_PUSH:
            begin
                state_next = S_POP;
                if ({1'b0, i_reg} > {1'b0, lo_reg} + 1'b1)
                begin
                    s_we    = 1'b1;
                    s_wdata = {lo_reg, idx_t'(i_reg - 1'b1)};
                    sp_next = sp_reg + 1'b1;
                end
            end
            S_ORD:
            begin
                k_addr = i_reg;
                if (count_reg == '0)
                begin
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                res_valid = 1'b1;
                if ({1'b0, i_reg} + 1'b1 == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_ORD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    assign sorted_key = k_rdata;
    assign final_res  = ({1'b0, i_reg} + 1'b1 == count_reg);
    assign dropped    = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        m_reg     <= m_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        pv_reg    <= pv_next;
        if (state_reg == S_LOAD && start && last)
        begin
            sdesc_reg <= desc_reg;
            ssgn_reg  <= sgn_reg;
        end
    end

endmodule

[test/testbench.sv]
// ============================================================================
// testbench
// self-checking test of the quicksort key sorter: key sets are loaded under
// each order and signedness setting, a local sorter predicts every result
// stream, and the results are compared field by field as they appear
// ============================================================================
module testbench
    import qks_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] skey;
        logic        fin;
        logic        drop;
    } sorted_rec_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] key;
    logic        last;
    logic        res_valid;
    logic [31:0] sorted_key;
    logic        final_res;
    logic        dropped;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    sorted_rec_t sorted_q[$];
    logic [31:0] set_keys[$];
    logic        set_overflow;
    logic        mdl_desc;
    logic        mdl_sgn;
    int          err_count;
    int          idle_pct;
    longint      cycle_count;

    quicksort_key_sorter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .key        (key),
        .last       (last),
        .res_valid  (res_valid),
        .sorted_key (sorted_key),
        .final_res  (final_res),
        .dropped    (dropped),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3000000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        err_count++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [31:0] order_key(input logic [31:0] k);
        logic [31:0] v;
        v = k;
        if (mdl_sgn)
            v[31] = ~v[31];
        if (mdl_desc)
            v = ~v;
        return v;
    endfunction

    // close the set: sort and queue the expected results
    function automatic void close_set();
        logic [31:0] s[$];
        logic [31:0] t;
        int          j;
        s = set_keys;
        for (int i = 1; i < s.size(); i++)
        begin
            t = s[i];
            j = i - 1;
            while (j >= 0 && order_key(s[j]) > order_key(t))
            begin
                s[j+1] = s[j];
                j--;
            end
            s[j+1] = t;
        end
        foreach (s[i])
            sorted_q.push_back('{s[i], i == s.size() - 1, set_overflow});
        set_keys.delete();
        set_overflow = 1'b0;
    endfunction

    always @(posedge clk)
    begin
        sorted_rec_t exp_rec;
        if (rst_n && res_valid)
        begin
            if (sorted_q.size() == 0)
                report("unexpected result", sorted_key, 32'h0);
            else
            begin
                exp_rec = sorted_q.pop_front();
                if (sorted_key !== exp_rec.skey)
                    report("sorted_key", sorted_key, exp_rec.skey);
                if (final_res !== exp_rec.fin)
                    report("final_res", {31'b0, final_res}, {31'b0, exp_rec.fin});
                if (dropped !== exp_rec.drop)
                    report("dropped", {31'b0, dropped}, {31'b0, exp_rec.drop});
            end
        end
    end

    task automatic send_key(input logic [31:0] k, input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        key   <= k;
        last  <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (set_keys.size() < MAX_KEYS)
            set_keys.push_back(k);
        else
            set_overflow = 1'b1;
        if (l)
            close_set();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_DESCENDING)
            mdl_desc = data[0];
        else
            mdl_sgn = data[0];
    endtask

    task automatic set_mode(input logic desc, input logic sgn);
        wait_drained();
        write_cfg(REG_DESCENDING, {$urandom} & 32'hffff_fffe | desc);
        write_cfg(REG_SIGNED_KEYS, {$urandom} & 32'hffff_fffe | sgn);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000 + $urandom_range(3);
            3: return 32'h7fff_fffc + $urandom_range(3);
            4: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_key(rand_key(), i == n - 1);
    endtask

    task automatic test_directed();
        send_key(32'h1234_5678, 1'b1);
        send_key(32'hffff_ffff, 1'b0);
        send_key(32'h0, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h7fff_ffff, 1'b0);
        send_key(32'h5555_5555, 1'b0);
        send_key(32'haaaa_aaaa, 1'b0);
        send_key(32'h5555_5555, 1'b1);
        set_mode(1'b1, 1'b1);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h7fff_ffff, 1'b0);
        send_key(32'hffff_ffff, 1'b0);
        send_key(32'h0, 1'b1);
    endtask

    // overflow: more than capacity keys, then a set that exactly fills the store
    task automatic test_overflow();
        set_mode(1'b0, 1'b1);
        for (int i = 0; i < MAX_KEYS + 3; i++)
            send_key(rand_key(), 1'b0);
        send_key(32'h0, 1'b1);
        send_set(MAX_KEYS);
    endtask

    task automatic test_random(input int items);
        int n;
        int sent;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(MAX_KEYS) + 1 : $urandom_range(12) + 1;
            send_set(n);
            sent += n;
            if ($urandom_range(3) == 0)
                set_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        key = 32'h0;
        last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_DESCENDING;
        cfg_data = 32'h0;
        mdl_desc = 1'b0;
        mdl_sgn = 1'b0;
        set_overflow = 1'b0;
        err_count = 0;
        idle_pct = 23;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        set_mode(1'b0, 1'b0);
        test_random(50);
        idle_pct = 62;
        set_mode(1'b1, 1'b0);
        test_random(50);
        idle_pct = 0;
        set_mode(1'b0, 1'b1);
        test_random(50);
        wait_drained();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
